@@ sv/assert_macros.svh @@
// Assertion macros shared by the boundary-condition modules.
// Depends on nothing; the user module must provide i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

@@ sv/dzh_pkg.sv @@
// Types and constants of the D2Q9 Zou-He boundary pipeline.
// Depends on nothing; used by dzh_div and d2q9_zou_he_boundary.
`timescale 1ns / 1ps
`default_nettype none

package dzh_pkg;

    localparam int DW                  = 32;
    localparam int Q_FRAC              = 24;
    localparam int Q_ONE               = 1 << Q_FRAC;
    localparam int SUM_W               = DW + 4;
    localparam int ABS_W               = SUM_W - 1;
    localparam int HI_SHIFT            = DW - Q_FRAC;
    localparam int DIV_STEPS           = DW;
    localparam int DIV_STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES          = DIV_STEPS / DIV_STEPS_PER_STAGE;
    localparam int QS_W                = DW + 2;
    localparam int PROD_W              = 2 * DW;
    localparam int M_W                 = PROD_W - 1 - Q_FRAC;
    localparam int DIG_W               = 8;
    localparam int D3_DIGITS           = (M_W + DIG_W - 1) / DIG_W;
    localparam int D3_W                = D3_DIGITS * DIG_W;
    localparam int D3_HI               = (D3_DIGITS + 1) / 2;
    localparam int FIN_W               = M_W + 3;

    localparam logic [DIG_W+1:0]  D3_RECIP = (DIG_W + 2)'(683);
    localparam logic [PROD_W-1:0] N_BIAS   = (PROD_W'(1) << (Q_FRAC + 1)) - PROD_W'(1);
    localparam logic [DW-1:0]     SAT_POS  = {1'b0, {(DW - 1){1'b1}}};
    localparam logic [DW-1:0]     SAT_NEG  = {1'b1, {(DW - 1){1'b0}}};

    localparam logic ACT_WEST_INLET  = 1'b0;
    localparam logic ACT_EAST_OUTLET = 1'b1;

    typedef struct packed {
        logic                 action;
        logic signed [DW-1:0] dist_0;
        logic signed [DW-1:0] dist_1;
        logic signed [DW-1:0] dist_2;
        logic signed [DW-1:0] dist_3;
        logic signed [DW-1:0] dist_4;
        logic signed [DW-1:0] dist_5;
        logic signed [DW-1:0] dist_6;
        logic signed [DW-1:0] dist_7;
        logic signed [DW-1:0] dist_8;
        logic signed [DW-1:0] prescribed_main;
        logic signed [DW-1:0] prescribed_side;
    } t_in;

    typedef struct packed {
        logic signed [DW-1:0] new_axis;
        logic signed [DW-1:0] new_diag_up;
        logic signed [DW-1:0] new_diag_down;
        logic signed [DW-1:0] derived_macro;
        logic                 divide_fault;
    } t_out;

    typedef struct packed {
        logic                 mode;
        logic                 fault;
        logic                 neg;
        logic                 ovf;
        logic signed [DW-1:0] base_a;
        logic signed [DW-1:0] base_up;
        logic signed [DW-1:0] base_dn;
        logic signed [DW-1:0] h;
        logic signed [DW-1:0] pm;
        logic signed [DW-1:0] ps;
    } t_side;

    typedef struct packed {
        logic [DW-1:0] rem;
        logic [DW-1:0] ql;
        logic [DW-1:0] den;
    } t_dwork;

endpackage

`default_nettype wire

@@ sv/dzh_div.sv @@
// Pipelined restoring divider producing an unsigned quotient, two bits per stage.
// Depends on dzh_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dzh_div (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire dzh_pkg::t_dwork i_work,
    input  wire dzh_pkg::t_side  i_side,
    output logic                 o_valid,
    output logic [dzh_pkg::DW-1:0] o_quo,
    output dzh_pkg::t_side       o_side
);
    import dzh_pkg::*;

    logic   r_valid [DIV_STAGES];
    t_dwork r_work  [DIV_STAGES];
    t_side  r_side  [DIV_STAGES];

    function automatic t_dwork div_step(input t_dwork w);
        logic [DW:0] t;
        t_dwork      s;
        t = {w.rem, w.ql[DW-1]};
        s = w;
        if (t >= {1'b0, w.den}) begin
            t    = t - {1'b0, w.den};
            s.ql = {w.ql[DW-2:0], 1'b1};
        end else begin
            s.ql = {w.ql[DW-2:0], 1'b0};
        end
        s.rem = t[DW-1:0];
        return s;
    endfunction

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic   v_in;
        t_dwork w_in;
        t_side  s_in;
        t_dwork n_w;

        if (k == 0) begin : g_first
            assign v_in = i_valid;
            assign w_in = i_work;
            assign s_in = i_side;
        end else begin : g_next
            assign v_in = r_valid[k-1];
            assign w_in = r_work[k-1];
            assign s_in = r_side[k-1];
        end

        always_comb begin
            n_w = w_in;
            for (int j = 0; j < DIV_STEPS_PER_STAGE; j++) begin
                n_w = div_step(n_w);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= v_in;
            end
            if (i_en) begin
                r_work[k] <= n_w;
                r_side[k] <= s_in;
            end
        end
    end

    assign o_valid = r_valid[DIV_STAGES-1];
    assign o_quo   = r_work[DIV_STAGES-1].ql;
    assign o_side  = r_side[DIV_STAGES-1];

    `ASSERT_CLK(a_den_nonzero, r_valid[0] |-> (r_work[0].den != '0), "divider holds a zero divisor")
    `ASSERT_CLK(a_rem_bound, o_valid |-> (r_work[DIV_STAGES-1].rem < r_work[DIV_STAGES-1].den), "partial remainder not below divisor")

endmodule

`default_nettype wire

@@ sv/d2q9_zou_he_boundary.sv @@
// Use of the block:
// One transaction on the input channel (i_valid, o_stall, i_data) carries a
// boundary cell: the mode, nine distributions and the prescribed values.
// One transaction on the output channel (o_valid, i_stall, o_result) carries
// the three rebuilt distributions, the derived macroscopic value and the
// divide fault flag, in the order the cells were accepted.
// The block is a pipeline of 25 register stages. A result passes stages 1
// and 2, the divider, stages 3 to 8 and the output register before it is
// shown on o_result, and can be taken at the following edge at the earliest.
// One cell is accepted in every cycle for as long as the receiver takes
// results; the 16-stage divider, two quotient bits per stage, sets the depth.
// Reset empties every stage and clears o_valid; no results are pending after it.
// While a result waits with i_stall high the whole pipeline holds and o_stall
// is raised, so nothing is lost or repeated; empty stages fill meanwhile
// only once the output is taken again.
// Depends on dzh_pkg, dzh_div and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module d2q9_zou_he_boundary (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire dzh_pkg::t_in  i_data,
    output logic               o_valid,
    input  wire logic          i_stall,
    output dzh_pkg::t_out      o_result
);
    import dzh_pkg::*;

    function automatic logic [DW-1:0] sat_dw(input logic signed [FIN_W-1:0] x);
        logic [DW-1:0] r;
        if ((&x[FIN_W-1:DW-1]) || (~|x[FIN_W-1:DW-1])) begin
            r = x[DW-1:0];
        end else if (x[FIN_W-1]) begin
            r = SAT_NEG;
        end else begin
            r = SAT_POS;
        end
        return r;
    endfunction

    function automatic logic [DIG_W+1:0] div3_digit(input logic [1:0] rem,
                                                   input logic [DIG_W-1:0] dig);
        logic [DIG_W+1:0]     v;
        logic [2*DIG_W+3:0]   p;
        logic [DIG_W-1:0]     q;
        logic [DIG_W+1:0]     r;
        v = {rem, dig};
        p = v * D3_RECIP;
        q = p[2*DIG_W+2:DIG_W+3];
        r = v - {1'b0, q, 1'b0} - {2'b00, q};
        return {q, r[1:0]};
    endfunction

    logic en;

    // Stage 1: sums, divisor, transverse term.
    logic                    in_outlet;
    logic signed [SUM_W-1:0] s_f0, s_f2, s_f4, s_k1, s_k2, s_k3;
    logic signed [SUM_W-1:0] n1_sum;
    logic signed [DW:0]      n1_den;
    logic signed [DW:0]      n1_hdiff;
    logic signed [DW:0]      n1_hsum;
    logic                    n1_fault;
    t_side                   n1_side;
    logic                    r1_valid;
    logic signed [SUM_W-1:0] r1_sum;
    logic [DW-1:0]           r1_den;
    t_side                   r1_side;

    always_comb begin
        in_outlet = (i_data.action != ACT_WEST_INLET);
        s_f0 = SUM_W'(i_data.dist_0);
        s_f2 = SUM_W'(i_data.dist_2);
        s_f4 = SUM_W'(i_data.dist_4);
        if (in_outlet) begin
            s_k1   = SUM_W'(i_data.dist_1);
            s_k2   = SUM_W'(i_data.dist_5);
            s_k3   = SUM_W'(i_data.dist_8);
            n1_den = (DW + 1)'(i_data.prescribed_main);
        end else begin
            s_k1   = SUM_W'(i_data.dist_3);
            s_k2   = SUM_W'(i_data.dist_6);
            s_k3   = SUM_W'(i_data.dist_7);
            n1_den = (DW + 1)'(Q_ONE) - (DW + 1)'(i_data.prescribed_main);
        end
        n1_sum   = s_f0 + s_f2 + s_f4 + ((s_k1 + s_k2 + s_k3) <<< 1);
        n1_fault = n1_den[DW] || (n1_den == '0);
        n1_hdiff = (DW + 1)'(i_data.dist_2) - (DW + 1)'(i_data.dist_4);
        n1_hsum  = n1_hdiff + $signed({{DW{1'b0}}, n1_hdiff[DW]});

        n1_side.mode    = in_outlet;
        n1_side.fault   = n1_fault;
        n1_side.neg     = 1'b0;
        n1_side.ovf     = 1'b0;
        n1_side.base_a  = in_outlet ? i_data.dist_1 : i_data.dist_3;
        n1_side.base_up = in_outlet ? i_data.dist_5 : i_data.dist_7;
        n1_side.base_dn = in_outlet ? i_data.dist_8 : i_data.dist_6;
        n1_side.h       = n1_hsum[DW:1];
        n1_side.pm      = i_data.prescribed_main;
        n1_side.ps      = i_data.prescribed_side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= i_valid;
        end
        if (en) begin
            r1_sum  <= n1_sum;
            r1_den  <= n1_fault ? DW'(1) : n1_den[DW-1:0];
            r1_side <= n1_side;
        end
    end

    // Stage 2: magnitude of the dividend and quotient overflow test.
    logic signed [SUM_W-1:0] n2_neg_sum;
    logic [ABS_W-1:0]        n2_abs;
    logic                    n2_ovf;
    t_dwork                  n2_work;
    t_side                   n2_side;
    logic                    r2_valid;
    t_dwork                  r2_work;
    t_side                   r2_side;

    always_comb begin
        n2_neg_sum = -r1_sum;
        n2_abs     = r1_sum[SUM_W-1] ? n2_neg_sum[ABS_W-1:0] : r1_sum[ABS_W-1:0];
        n2_ovf     = (DW'(n2_abs[ABS_W-1:HI_SHIFT]) >= r1_den);
        n2_work.rem = n2_ovf ? '0 : DW'(n2_abs[ABS_W-1:HI_SHIFT]);
        n2_work.ql  = {n2_abs[HI_SHIFT-1:0], {Q_FRAC{1'b0}}};
        n2_work.den = r1_den;
        n2_side     = r1_side;
        n2_side.neg = r1_sum[SUM_W-1];
        n2_side.ovf = n2_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid;
        end
        if (en) begin
            r2_work <= n2_work;
            r2_side <= n2_side;
        end
    end

    logic          d_valid;
    logic [DW-1:0] d_quo;
    t_side         d_side;

    dzh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r2_valid),
        .i_work  (r2_work),
        .i_side  (r2_side),
        .o_valid (d_valid),
        .o_quo   (d_quo),
        .o_side  (d_side)
    );

    // Stage 3: signed, offset and saturated macroscopic value.
    logic [DW-1:0]          n3_qc;
    logic signed [QS_W-1:0] n3_qx;
    logic signed [QS_W-1:0] n3_qs;
    logic                   r3_valid;
    logic signed [DW-1:0]   r3_macro;
    t_side                  r3_side;

    always_comb begin
        n3_qc = d_side.ovf ? '1 : d_quo;
        n3_qx = {2'b00, n3_qc};
        n3_qs = d_side.neg ? -n3_qx : n3_qx;
        if (d_side.mode == ACT_EAST_OUTLET) begin
            n3_qs = n3_qs - QS_W'(Q_ONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en) begin
            r3_valid <= d_valid;
        end
        if (en) begin
            r3_macro <= sat_dw(FIN_W'(n3_qs));
            r3_side  <= d_side;
        end
    end

    // Stage 4: products with the prescribed values.
    logic                     r4_valid;
    logic signed [PROD_W-1:0] r4_mprod;
    logic signed [PROD_W-1:0] r4_nprod;
    logic signed [DW-1:0]     r4_macro;
    t_side                    r4_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (en) begin
            r4_valid <= r3_valid;
        end
        if (en) begin
            r4_mprod <= r3_macro * r3_side.pm;
            r4_nprod <= r3_macro * r3_side.ps;
            r4_macro <= r3_macro;
            r4_side  <= r3_side;
        end
    end

    // Stage 5: rescale, magnitude of m and half of n.
    logic signed [PROD_W-1:0] n5_mneg;
    logic [PROD_W-1:0]        n5_mabs;
    logic [PROD_W-1:0]        n5_nb;
    logic                     r5_valid;
    logic [M_W-1:0]           r5_mag;
    logic                     r5_msign;
    logic signed [M_W-1:0]    r5_n2;
    logic signed [DW-1:0]     r5_macro;
    t_side                    r5_side;

    always_comb begin
        n5_mneg = -r4_mprod;
        n5_mabs = r4_mprod[PROD_W-1] ? n5_mneg : r4_mprod;
        n5_nb   = r4_nprod + (r4_nprod[PROD_W-1] ? N_BIAS : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (en) begin
            r5_valid <= r4_valid;
        end
        if (en) begin
            r5_mag   <= n5_mabs[PROD_W-2:Q_FRAC];
            r5_msign <= r4_mprod[PROD_W-1];
            r5_n2    <= n5_nb[PROD_W-1:Q_FRAC+1];
            r5_macro <= r4_macro;
            r5_side  <= r4_side;
        end
    end

    // Stages 6 and 7: division of the magnitude by three, one digit a step.
    logic [D3_W-1:0]        n6_q;
    logic [1:0]             n6_rem;
    logic [DIG_W+1:0]       n6_step;
    logic                   r6_valid;
    logic [D3_W-1:0]        r6_q;
    logic [1:0]             r6_rem;
    logic                   r6_msign;
    logic signed [M_W-1:0]  r6_n2;
    logic signed [DW-1:0]   r6_macro;
    t_side                  r6_side;

    always_comb begin
        n6_q   = D3_W'(r5_mag);
        n6_rem = 2'b00;
        n6_step = '0;
        for (int k = D3_DIGITS - 1; k >= D3_DIGITS - D3_HI; k--) begin
            n6_step = div3_digit(n6_rem, n6_q[k*DIG_W +: DIG_W]);
            n6_q[k*DIG_W +: DIG_W] = n6_step[DIG_W+1:2];
            n6_rem = n6_step[1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else if (en) begin
            r6_valid <= r5_valid;
        end
        if (en) begin
            r6_q     <= n6_q;
            r6_rem   <= n6_rem;
            r6_msign <= r5_msign;
            r6_n2    <= r5_n2;
            r6_macro <= r5_macro;
            r6_side  <= r5_side;
        end
    end

    logic [D3_W-1:0]        n7_q;
    logic [1:0]             n7_rem;
    logic [DIG_W+1:0]       n7_step;
    logic                   r7_valid;
    logic [D3_W-1:0]        r7_q;
    logic [1:0]             r7_rem;
    logic                   r7_msign;
    logic signed [M_W-1:0]  r7_n2;
    logic signed [DW-1:0]   r7_macro;
    t_side                  r7_side;

    always_comb begin
        n7_q   = r6_q;
        n7_rem = r6_rem;
        n7_step = '0;
        for (int k = D3_DIGITS - D3_HI - 1; k >= 0; k--) begin
            n7_step = div3_digit(n7_rem, n7_q[k*DIG_W +: DIG_W]);
            n7_q[k*DIG_W +: DIG_W] = n7_step[DIG_W+1:2];
            n7_rem = n7_step[1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_valid <= 1'b0;
        end else if (en) begin
            r7_valid <= r6_valid;
        end
        if (en) begin
            r7_q     <= n7_q;
            r7_rem   <= n7_rem;
            r7_msign <= r6_msign;
            r7_n2    <= r6_n2;
            r7_macro <= r6_macro;
            r7_side  <= r6_side;
        end
    end

    // Stage 8: signed correction terms for each mode.
    logic                    n8_outlet;
    logic                    n8_flip;
    logic signed [FIN_W-1:0] n8_t23;
    logic signed [FIN_W-1:0] n8_t6;
    logic signed [FIN_W-1:0] n8_h;
    logic                    r8_valid;
    logic signed [FIN_W-1:0] r8_t23s;
    logic signed [FIN_W-1:0] r8_t6s;
    logic signed [FIN_W-1:0] r8_hu;
    logic signed [FIN_W-1:0] r8_nu;
    logic signed [DW-1:0]    r8_macro;
    t_side                   r8_side;

    always_comb begin
        n8_outlet = (r7_side.mode == ACT_EAST_OUTLET);
        n8_flip   = r7_msign ^ n8_outlet;
        n8_t23    = FIN_W'({r7_q, 1'b0}) + FIN_W'(r7_rem == 2'd2);
        n8_t6     = FIN_W'(r7_q[D3_W-1:1]);
        n8_h      = FIN_W'(r7_side.h);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_valid <= 1'b0;
        end else if (en) begin
            r8_valid <= r7_valid;
        end
        if (en) begin
            r8_t23s  <= n8_flip ? -n8_t23 : n8_t23;
            r8_t6s   <= n8_flip ? -n8_t6 : n8_t6;
            r8_hu    <= n8_outlet ? n8_h : -n8_h;
            r8_nu    <= n8_outlet ? '0 : FIN_W'(r7_n2);
            r8_macro <= r7_macro;
            r8_side  <= r7_side;
        end
    end

    // Output register: final sums and saturation.
    logic signed [FIN_W-1:0] n_sum_a;
    logic signed [FIN_W-1:0] n_sum_up;
    logic signed [FIN_W-1:0] n_sum_dn;
    t_out                    n_out;
    logic                    r_out_valid;
    t_out                    r_out;

    always_comb begin
        n_sum_a  = FIN_W'(r8_side.base_a) + r8_t23s;
        n_sum_up = FIN_W'(r8_side.base_up) + r8_t6s + r8_nu + r8_hu;
        n_sum_dn = FIN_W'(r8_side.base_dn) + r8_t6s - r8_nu - r8_hu;
        if (r8_side.fault) begin
            n_out.new_axis      = SAT_POS;
            n_out.new_diag_up   = SAT_POS;
            n_out.new_diag_down = SAT_POS;
            n_out.derived_macro = SAT_POS;
            n_out.divide_fault  = 1'b1;
        end else begin
            n_out.new_axis      = sat_dw(n_sum_a);
            n_out.new_diag_up   = sat_dw(n_sum_up);
            n_out.new_diag_down = sat_dw(n_sum_dn);
            n_out.derived_macro = r8_macro;
            n_out.divide_fault  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r8_valid;
        end
        if (en) begin
            r_out <= n_out;
        end
    end

    assign en       = !r_out_valid || !i_stall;
    assign o_stall  = !en;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    `ASSERT_RST(a_reset_empties, !i_rst_n |=> !o_valid, "result valid right after reset")
    `ASSERT_CLK(a_fault_saturates, (o_valid && o_result.divide_fault) |-> ((o_result.new_axis == SAT_POS) && (o_result.derived_macro == SAT_POS)), "faulted transaction not saturated")
    `ASSERT_CLK(a_density_sign, (r3_valid && !r3_side.fault && (r3_side.mode == ACT_WEST_INLET) && r3_macro[DW-1]) |-> r3_side.neg, "negative density from a non-negative sum")

endmodule

`default_nettype wire
